[design/bar_pkg.sv]
`default_nettype none

package bar_pkg;

   // sequence space
   localparam int          SEQ_BITS = 12;
   localparam int          SEQ_SPAN = 'h1000;
   localparam logic [11:0] SEQ_MSK  = 12'hfff;
   localparam logic [11:0] SEQ_HALF = 12'h800;

   // port widths
   localparam int TAG_PORT_BITS = 16;
   localparam int WSIZE_BITS    = 5;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 12;

   // parameter defaults
   localparam int DEF_WINDOW   = 16;
   localparam int DEF_TAG_BITS = 16;
   localparam int QUEUE_DEPTH  = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SESSION_ENABLE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_SEQ      = 2'd2;

   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 5'd16;

   // result actions
   localparam logic ACT_DELIVER = 1'b0;
   localparam logic ACT_DROP    = 1'b1;

   // session settings seen by the back end
   typedef struct packed {
      logic                enable;
      logic [SEQ_BITS-1:0] start_seq;
      logic                restart;
   } cfg_type;

   // queue handshake
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // a is older than b in modulo-4096 sequence space
   function automatic logic seq_older(input logic [SEQ_BITS-1:0] a,
                                      input logic [SEQ_BITS-1:0] b);
      logic [SEQ_BITS-1:0] d;
      d = a - b;
      return d > SEQ_HALF;
   endfunction

endpackage

`default_nettype wire

[design/block_ack_rx_reorder.sv]
// An item's slot index is worked out one remainder bit a cycle; the item then passes through
// the queue to the back end, which walks slots from the head as it gives the item's results.
// The front end takes a new item only after it has pushed the last one into the queue, and it
// waits while the queue is full; the back end finishes one item before it takes the next.
// Results cannot be stalled; each shows for one cycle on rsp_strobe.
// Reset is synchronous: registers return to their reset values and the session restarts.
`default_nettype none

module block_ack_rx_reorder import bar_pkg::*; #(
   parameter int WINDOW   = DEF_WINDOW,
   parameter int TAG_BITS = DEF_TAG_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [SEQ_BITS-1:0]      req_seq_num,
   input  wire logic [TAG_PORT_BITS-1:0] req_frame_tag,
   output logic                          rsp_strobe,
   output logic [TAG_PORT_BITS-1:0]      rsp_out_tag,
   output logic                          rsp_action,
   output logic                          rsp_last,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int SZ_W   = $clog2(WINDOW+1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TW     = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;
   localparam int QW     = SEQ_BITS + TW + SLOT_W;
   localparam logic [WSIZE_BITS:0] WIN_LIMIT = (WSIZE_BITS+1)'(WINDOW);

   logic                  enable_ff;
   logic [WSIZE_BITS-1:0] wsize_ff;
   logic [SEQ_BITS-1:0]   start_ff;
   logic                  restart_ff;
   logic [SZ_W-1:0]       size;
   cfg_type               cfg;
   q_ctl_type             q_ctl;
   q_stat_type            q_stat;
   logic                  q_push, q_pop;
   logic [QW-1:0]         q_wr_data, q_rd_data;

   // configuration registers; a write to any of the three defined indexes restarts the session
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         wsize_ff   <= WSIZE_RESET;
         start_ff   <= '0;
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SESSION_ENABLE: begin
                  enable_ff  <= csr_wdata[0];
                  restart_ff <= 1'b1;
               end
               CSR_WINDOW_SIZE: begin
                  wsize_ff   <= csr_wdata[WSIZE_BITS-1:0];
                  restart_ff <= 1'b1;
               end
               CSR_START_SEQ: begin
                  start_ff   <= csr_wdata[SEQ_BITS-1:0];
                  restart_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // window size in use: zero counts as one, capped at the slot count
   always_comb begin
      if (wsize_ff == '0) begin
         size = SZ_W'(1);
      end else if ({1'b0, wsize_ff} > WIN_LIMIT) begin
         size = SZ_W'(WINDOW);
      end else begin
         size = SZ_W'(wsize_ff);
      end
   end

   assign cfg.enable    = enable_ff;
   assign cfg.start_seq = start_ff;
   assign cfg.restart   = restart_ff;
   assign q_ctl.push    = q_push;
   assign q_ctl.pop     = q_pop;

   bar_front #(
      .WINDOW   (WINDOW),
      .TAG_BITS (TAG_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .seq_num   (req_seq_num),
      .frame_tag (req_frame_tag),
      .start_seq (start_ff),
      .size      (size),
      .q_full    (q_stat.full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   bar_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .stat    (q_stat),
      .wr_data (q_wr_data),
      .rd_data (q_rd_data)
   );

   bar_back #(
      .WINDOW   (WINDOW),
      .TAG_BITS (TAG_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .size        (size),
      .q_empty     (q_stat.empty),
      .q_pop       (q_pop),
      .q_data      (q_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_out_tag (rsp_out_tag),
      .rsp_action  (rsp_action),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

[design/bar_front.sv]
`default_nettype none

module bar_front import bar_pkg::*; #(
   parameter int WINDOW   = DEF_WINDOW,
   parameter int TAG_BITS = DEF_TAG_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [SEQ_BITS-1:0] seq_num,
   input  wire logic [TAG_PORT_BITS-1:0] frame_tag,
   input  wire logic [SEQ_BITS-1:0] start_seq,
   input  wire logic [$clog2(WINDOW+1)-1:0] size,
   input  wire logic                q_full,
   output logic                     q_push,
   output logic [SEQ_BITS + ((TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS)
                + ((WINDOW > 1) ? $clog2(WINDOW) : 1) - 1:0] q_data
);

   localparam int SZ_W   = $clog2(WINDOW+1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TW     = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;
   localparam int CNT_W  = $clog2(SEQ_BITS);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_type;

   state_type           state_ff, state_in;
   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic [TW-1:0]       tag_ff, tag_in;
   logic [SEQ_BITS-1:0] off_ff, off_in;
   logic [SZ_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SZ_W:0]       cand;

   // one remainder bit per cycle: slot = (seq - start) mod size
   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      tag_in   = tag_ff;
      off_in   = off_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      q_push   = 1'b0;
      cand     = {rem_ff, off_ff[SEQ_BITS-1]};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               seq_in   = seq_num;
               tag_in   = frame_tag[TW-1:0];
               off_in   = seq_num - start_seq;
               rem_in   = '0;
               cnt_in   = CNT_W'(SEQ_BITS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (cand >= {1'b0, size}) begin
               rem_in = SZ_W'(cand - {1'b0, size});
            end else begin
               rem_in = SZ_W'(cand);
            end
            off_in = off_ff << 1;
            if (cnt_ff == '0) begin
               state_in = S_PUSH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      seq_ff <= seq_in;
      tag_ff <= tag_in;
      off_ff <= off_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy   = (state_ff != S_IDLE);
   assign q_data = {seq_ff, tag_ff, SLOT_W'(rem_ff)};

endmodule

`default_nettype wire

[design/bar_fifo.sv]
`default_nettype none

module bar_fifo import bar_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire q_ctl_type        ctl,
   output q_stat_type            stat,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0]      rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = ctl.push && !stat.full;
   assign do_pop     = ctl.pop && !stat.empty;
   assign rd_data    = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[design/bar_back.sv]
`default_nettype none

module bar_back import bar_pkg::*; #(
   parameter int WINDOW   = DEF_WINDOW,
   parameter int TAG_BITS = DEF_TAG_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic [$clog2(WINDOW+1)-1:0] size,
   input  wire logic                q_empty,
   output logic                     q_pop,
   input  wire logic [SEQ_BITS + ((TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS)
                      + ((WINDOW > 1) ? $clog2(WINDOW) : 1) - 1:0] q_data,
   output logic                     rsp_strobe,
   output logic [TAG_PORT_BITS-1:0] rsp_out_tag,
   output logic                     rsp_action,
   output logic                     rsp_last
);

   localparam int SZ_W   = $clog2(WINDOW+1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TW     = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;

   typedef enum logic [2:0] {S_IDLE, S_EVAL, S_JUMP, S_PLACE, S_RUN, S_DONE} state_type;

   // 4096 mod k, needed when the new head wraps below the start sequence
   logic [SZ_W-1:0] rem_tab [WINDOW+1];
   for (genvar k = 0; k <= WINDOW; k++) begin : g_rem
      if (k == 0) begin : g_zero
         assign rem_tab[k] = '0;
      end else begin : g_val
         localparam int REM = SEQ_SPAN % k;
         assign rem_tab[k] = SZ_W'(REM);
      end
   end

   state_type           state_ff, state_in;
   logic [SEQ_BITS-1:0] cur_seq_ff, cur_seq_in;
   logic [TW-1:0]       cur_tag_ff, cur_tag_in;
   logic [SLOT_W-1:0]   cur_slot_ff, cur_slot_in;
   logic [SEQ_BITS-1:0] head_ff, head_in;
   logic [SLOT_W-1:0]   head_slot_ff, head_slot_in;
   logic [SZ_W-1:0]     count_ff, count_in;
   logic [WINDOW-1:0]   valid_ff, valid_in;
   logic [TW-1:0]       slot_tag_ff [WINDOW];
   logic [SEQ_BITS-1:0] nh_ff, nh_in;
   logic [SLOT_W-1:0]   nh_slot_ff, nh_slot_in;
   logic [SEQ_BITS-1:0] dist_ff, dist_in;
   logic                pend_ff, pend_in;
   logic [TW-1:0]       pend_tag_ff, pend_tag_in;
   logic                pend_act_ff, pend_act_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [TW-1:0]       rsp_tag_ff, rsp_tag_in;
   logic                rsp_act_ff, rsp_act_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                slot_we;
   logic [SLOT_W-1:0]   slot_wa;
   logic                emit, finish;
   logic [TW-1:0]       emit_tag;
   logic                emit_act;

   logic [SEQ_BITS-1:0] head_off, cur_off, win_end, nh_calc;
   logic [SLOT_W-1:0]   head_slot_inc, nh_slot_calc;
   logic [SZ_W:0]       slot_p1, wrap_sum;
   logic                head_valid, wrap_case;

   // slot of the head after it steps by one
   assign head_off      = head_ff - cfg.start_seq;
   assign head_slot_inc = (head_off == SEQ_MSK) ? '0 :
                          ((SZ_W'(head_slot_ff) + 1'b1) == size) ? '0 : head_slot_ff + 1'b1;
   assign head_valid    = valid_ff[head_slot_ff];

   // new head and its slot for a frame beyond the window
   assign cur_off   = cur_seq_ff - cfg.start_seq;
   assign win_end   = head_ff + SEQ_BITS'(size);
   assign nh_calc   = cur_seq_ff - SEQ_BITS'(size) + 1'b1;
   assign wrap_case = ({1'b0, cur_off} + 1'b1) < (SEQ_BITS+1)'(size);
   assign slot_p1   = (SZ_W+1)'(cur_slot_ff) + 1'b1;
   assign wrap_sum  = slot_p1 + (SZ_W+1)'(rem_tab[size]);
   always_comb begin
      if (wrap_case) begin
         nh_slot_calc = (wrap_sum >= {1'b0, size}) ? SLOT_W'(wrap_sum - {1'b0, size})
                                                   : SLOT_W'(wrap_sum);
      end else begin
         nh_slot_calc = (slot_p1 == {1'b0, size}) ? '0 : SLOT_W'(slot_p1);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_seq_in   = cur_seq_ff;
      cur_tag_in   = cur_tag_ff;
      cur_slot_in  = cur_slot_ff;
      head_in      = head_ff;
      head_slot_in = head_slot_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      nh_in        = nh_ff;
      nh_slot_in   = nh_slot_ff;
      dist_in      = dist_ff;
      q_pop        = 1'b0;
      slot_we      = 1'b0;
      slot_wa      = cur_slot_ff;
      emit         = 1'b0;
      emit_tag     = cur_tag_ff;
      emit_act     = ACT_DELIVER;
      finish       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               cur_seq_in  = q_data[SLOT_W+TW +: SEQ_BITS];
               cur_tag_in  = q_data[SLOT_W +: TW];
               cur_slot_in = q_data[SLOT_W-1:0];
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!cfg.enable) begin
               emit     = 1'b1;
               state_in = S_DONE;
            end else if (seq_older(cur_seq_ff, head_ff)) begin
               emit     = 1'b1;
               emit_act = ACT_DROP;
               state_in = S_DONE;
            end else if (!seq_older(cur_seq_ff, win_end) && seq_older(head_ff, nh_calc)) begin
               nh_in      = nh_calc;
               nh_slot_in = nh_slot_calc;
               dist_in    = nh_calc - head_ff;
               state_in   = S_JUMP;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_JUMP: begin
            // walk the head forward, delivering what it passes
            if (dist_ff != '0 && count_ff != '0) begin
               if (head_valid) begin
                  emit                   = 1'b1;
                  emit_tag               = slot_tag_ff[head_slot_ff];
                  valid_in[head_slot_ff] = 1'b0;
                  count_in               = count_ff - 1'b1;
               end
               head_in      = head_ff + 1'b1;
               head_slot_in = head_slot_inc;
               dist_in      = dist_ff - 1'b1;
            end else begin
               head_in      = nh_ff;
               head_slot_in = nh_slot_ff;
               state_in     = S_PLACE;
            end
         end
         S_PLACE: begin
            if (valid_ff[cur_slot_ff]) begin
               emit     = 1'b1;
               emit_act = ACT_DROP;
               state_in = S_DONE;
            end else if (cur_seq_ff == head_ff && count_ff == '0) begin
               emit         = 1'b1;
               head_in      = head_ff + 1'b1;
               head_slot_in = head_slot_inc;
               state_in     = S_DONE;
            end else begin
               slot_we               = 1'b1;
               valid_in[cur_slot_ff] = 1'b1;
               count_in              = count_ff + 1'b1;
               state_in              = S_RUN;
            end
         end
         S_RUN: begin
            // release the unbroken run from the head
            if (head_valid) begin
               emit                   = 1'b1;
               emit_tag               = slot_tag_ff[head_slot_ff];
               valid_in[head_slot_ff] = 1'b0;
               count_in               = count_ff - 1'b1;
               head_in                = head_ff + 1'b1;
               head_slot_in           = head_slot_inc;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // a write to any defined register restarts the session
      if (cfg.restart) begin
         head_in      = cfg.start_seq;
         head_slot_in = '0;
         count_in     = '0;
         valid_in     = '0;
      end
   end

   // hold one result back so the final one can carry the last flag
   always_comb begin
      pend_in       = pend_ff;
      pend_tag_in   = pend_tag_ff;
      pend_act_in   = pend_act_ff;
      rsp_strobe_in = 1'b0;
      rsp_tag_in    = pend_tag_ff;
      rsp_act_in    = pend_act_ff;
      rsp_last_in   = 1'b0;
      if (emit) begin
         rsp_strobe_in = pend_ff;
         pend_in       = 1'b1;
         pend_tag_in   = emit_tag;
         pend_act_in   = emit_act;
      end else if (finish) begin
         rsp_strobe_in = pend_ff;
         rsp_last_in   = 1'b1;
         pend_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         head_slot_ff  <= '0;
         count_ff      <= '0;
         valid_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         head_slot_ff  <= head_slot_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_seq_ff  <= cur_seq_in;
      cur_tag_ff  <= cur_tag_in;
      cur_slot_ff <= cur_slot_in;
      nh_ff       <= nh_in;
      nh_slot_ff  <= nh_slot_in;
      dist_ff     <= dist_in;
      pend_tag_ff <= pend_tag_in;
      pend_act_ff <= pend_act_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_last_ff <= rsp_last_in;
      if (slot_we) begin
         slot_tag_ff[slot_wa] <= cur_tag_ff;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_out_tag = TAG_PORT_BITS'(rsp_tag_ff);
   assign rsp_action  = rsp_act_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

`default_nettype wire
